// File: src/hsd_pkg.sv
// shared types, widths and codes for the hamming sec/secded decoder
// no dependencies
package hsd_pkg;

    localparam int CW_W   = 64;
    localparam int DATA_W = 57;
    localparam int POS_W  = 6;
    localparam int K_W    = 3;
    localparam int CFG_W  = 3;
    localparam int IDX_W  = 1;

    localparam logic [K_W-1:0] K_MIN = 3'd2;
    localparam logic [K_W-1:0] K_TOP = 3'd6;

    localparam logic [IDX_W-1:0] CFG_SECDED_MODE = 1'd0;
    localparam logic [IDX_W-1:0] CFG_LENGTH_LOG2 = 1'd1;

    localparam logic [1:0] STAT_NONE      = 2'd0;
    localparam logic [1:0] STAT_CORRECTED = 2'd1;
    localparam logic [1:0] STAT_DOUBLE    = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic [POS_W-1:0]  epos;
    } t_result;

    // code position that carries data bit idx
    function automatic int data_pos(input int idx);
        int p;
        int n;
        int res;
        n   = 0;
        res = 0;
        for (p = 1; p < CW_W; p++) begin
            if ((p & (p - 1)) != 0) begin
                if (n == idx) res = p;
                n++;
            end
        end
        return res;
    endfunction

endpackage

// File: src/hsd_decode.sv
// syndrome, parity, single-bit correction and data extraction for one codeword
// depends on hsd_pkg
module hsd_decode (
    input  logic [hsd_pkg::CW_W-1:0] i_codeword,
    input  logic                     i_secded,
    input  logic [hsd_pkg::K_W-1:0]  i_k,
    output hsd_pkg::t_result         o_result
);

    logic [hsd_pkg::CW_W-1:0]  pos;
    logic [hsd_pkg::CW_W-1:0]  corr;
    logic [hsd_pkg::POS_W-1:0] syn;
    logic                      par;
    logic                      dbl;
    logic [hsd_pkg::DATA_W-1:0] data;

    // map codeword bits onto code positions, drop positions beyond the length
    always_comb begin
        pos = '0;
        for (int p = 0; p < hsd_pkg::CW_W; p++) begin
            if ((7'(p) >> i_k) == 7'd0) begin
                if (i_secded) begin
                    pos[p] = i_codeword[p];
                end else if (p != 0) begin
                    pos[p] = i_codeword[p-1];
                end
            end
        end
    end

    always_comb begin
        syn = '0;
        for (int b = 0; b < hsd_pkg::POS_W; b++) begin
            for (int p = 0; p < hsd_pkg::CW_W; p++) begin
                if (p[b]) syn[b] = syn[b] ^ pos[p];
            end
        end
    end

    assign par  = ^pos;
    assign dbl  = i_secded && (syn != '0) && !par;
    assign corr = (syn != '0) ? (pos ^ (64'd1 << syn)) : pos;

    for (genvar i = 0; i < hsd_pkg::DATA_W; i++) begin : g_data
        assign data[i] = corr[6'(hsd_pkg::data_pos(i))];
    end

    always_comb begin
        if (dbl) begin
            o_result.data   = '0;
            o_result.status = hsd_pkg::STAT_DOUBLE;
            o_result.epos   = '0;
        end else if (syn != '0) begin
            o_result.data   = data;
            o_result.status = hsd_pkg::STAT_CORRECTED;
            o_result.epos   = syn;
        end else if (i_secded && par) begin
            o_result.data   = data;
            o_result.status = hsd_pkg::STAT_CORRECTED;
            o_result.epos   = '0;
        end else begin
            o_result.data   = data;
            o_result.status = hsd_pkg::STAT_NONE;
            o_result.epos   = '0;
        end
    end

endmodule

// File: src/hamming_sec_secded_decoder.sv
// top level of the hamming sec/secded decoder: config registers, input and result stages
// depends on hsd_pkg and hsd_decode
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_codeword
//  result    out        o_valid / i_ready   o_data_out, o_status, o_error_position
//  config    in         i_cfg_wr_en         i_cfg_index, i_cfg_wdata
//
// input beat to result beat passes input register, decode, result register
// one beat per cycle sustained while i_ready stays high; the decode is a single pass between the two registers
// a stalled result register holds, the input register then fills, then o_ready drops
// synchronous active-low reset empties both stages; secded_mode = 1, length_log2 = 6
module hamming_sec_secded_decoder #(
    parameter int MAX_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hsd_pkg::CW_W-1:0]    i_codeword,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hsd_pkg::DATA_W-1:0]  o_data_out,
    output logic [1:0]                  o_status,
    output logic [hsd_pkg::POS_W-1:0]   o_error_position,
    input  logic                        i_cfg_wr_en,
    input  logic [hsd_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [hsd_pkg::CFG_W-1:0]   i_cfg_wdata
);

    localparam int KMAX_RAW = $clog2(MAX_BITS + 1) - 1;
    localparam logic [hsd_pkg::K_W-1:0] KMAX =
        (KMAX_RAW > 6) ? hsd_pkg::K_TOP : hsd_pkg::K_W'(KMAX_RAW);

    logic                       r_secded;
    logic [hsd_pkg::K_W-1:0]    r_klog;
    logic                       r_a_vld;
    logic [hsd_pkg::CW_W-1:0]   r_a_cw;
    logic                       r_b_vld;
    hsd_pkg::t_result           r_b_res;
    hsd_pkg::t_result           n_b_res;
    logic [hsd_pkg::K_W-1:0]    k_eff;
    logic                       a_ready;
    logic                       b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secded <= 1'b1;
            r_klog   <= hsd_pkg::K_TOP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                hsd_pkg::CFG_SECDED_MODE: r_secded <= i_cfg_wdata[0];
                hsd_pkg::CFG_LENGTH_LOG2: r_klog   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamp k to the legal range and to what MAX_BITS allows
    always_comb begin
        if (r_klog < hsd_pkg::K_MIN) begin
            k_eff = hsd_pkg::K_MIN;
        end else if (r_klog > KMAX) begin
            k_eff = KMAX;
        end else begin
            k_eff = r_klog;
        end
    end

    assign b_ready = !r_b_vld || i_ready;
    assign a_ready = !r_a_vld || b_ready;
    assign o_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_ready) r_a_vld <= i_valid;
            if (b_ready) r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) r_a_cw  <= i_codeword;
        if (b_ready && r_a_vld) r_b_res <= n_b_res;
    end

    hsd_decode u_decode (
        .i_codeword (r_a_cw),
        .i_secded   (r_secded),
        .i_k        (k_eff),
        .o_result   (n_b_res)
    );

    assign o_valid          = r_b_vld;
    assign o_data_out       = r_b_res.data;
    assign o_status         = r_b_res.status;
    assign o_error_position = r_b_res.epos;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == hsd_pkg::STAT_NONE || o_status == hsd_pkg::STAT_CORRECTED ||
                     o_status == hsd_pkg::STAT_DOUBLE))
        else $error("illegal status code");

    a_double_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == hsd_pkg::STAT_DOUBLE) |->
            (o_data_out == '0 && o_error_position == '0))
        else $error("double error result carries data or position");

    a_none_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == hsd_pkg::STAT_NONE) |-> (o_error_position == '0))
        else $error("clean beat reports a position");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && r_b_vld && !i_ready) |=> (r_a_vld && r_b_vld))
        else $error("beat lost during stall");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!r_a_vld && !r_b_vld))
        else $error("pipeline not empty after reset");

endmodule

// File: sim/tb_hamming_sec_secded_decoder.sv
`timescale 1ns / 100ps
// testbench for hamming_sec_secded_decoder: directed table, then random codewords, mostly encoded
// with injected bit errors; results checked against table values or an in-bench decode predictor
// depends on hsd_pkg and the decoder rtl
module tb_hamming_sec_secded_decoder;

    typedef struct {
        bit                         sd;
        logic [2:0]                 klog;
        logic [hsd_pkg::CW_W-1:0]   cw;
        bit                         typed;
        logic [hsd_pkg::DATA_W-1:0] want_data;
        logic [1:0]                 want_status;
        logic [hsd_pkg::POS_W-1:0]  want_pos;
    } t_vector;

    localparam logic [hsd_pkg::DATA_W-1:0] ALL_DATA = {hsd_pkg::DATA_W{1'b1}};
    localparam logic [hsd_pkg::CW_W-1:0]   ALL_CW   = {hsd_pkg::CW_W{1'b1}};
    localparam int                         N_DIR    = 25;
    localparam int                         N_SEG    = 22;
    localparam int                         SEG_LEN  = 50;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [hsd_pkg::CW_W-1:0]     i_codeword = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [hsd_pkg::DATA_W-1:0]   o_data_out;
    logic [1:0]                   o_status;
    logic [hsd_pkg::POS_W-1:0]    o_error_position;
    logic                         i_cfg_wr_en = 1'b0;
    logic [hsd_pkg::IDX_W-1:0]    i_cfg_index = '0;
    logic [hsd_pkg::CFG_W-1:0]    i_cfg_wdata = '0;

    hsd_pkg::t_result pending_results[$];
    bit               mode_shadow = 1'b1;
    logic [2:0]       klog_shadow = 3'd6;
    int               send_idle_pct = 16;
    int               recv_idle_pct = 52;
    int               mismatches = 0;
    int               beats_out = 0;
    int               words_sent = 0;
    int               hold_cnt = 0;
    bit               pressure_done = 1'b0;

    t_vector dir_vectors [N_DIR] = '{
        '{1'b1, 3'd6, 64'h0,                   1'b1, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd6, 64'h1,                   1'b1, '0,       hsd_pkg::STAT_CORRECTED, 6'd0},
        '{1'b1, 3'd6, 64'h8,                   1'b1, '0,       hsd_pkg::STAT_CORRECTED, 6'd3},
        '{1'b1, 3'd6, 64'h28,                  1'b1, '0,       hsd_pkg::STAT_DOUBLE,    6'd0},
        '{1'b1, 3'd6, ALL_CW,                  1'b1, ALL_DATA, hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd6, 64'h8000_0000_0000_0000, 1'b1, '0,       hsd_pkg::STAT_CORRECTED, 6'd63},
        '{1'b1, 3'd6, 64'h0123_4567_89AB_CDEF, 1'b0, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd6, 64'h0,                   1'b1, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd6, ALL_CW,                  1'b1, ALL_DATA, hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd6, 64'h8000_0000_0000_0000, 1'b1, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd6, 64'h4000_0000_0000_0000, 1'b1, '0,       hsd_pkg::STAT_CORRECTED, 6'd63},
        '{1'b0, 3'd6, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd2, 64'h4,                   1'b1, '0,       hsd_pkg::STAT_CORRECTED, 6'd3},
        '{1'b0, 3'd2, 64'h7,                   1'b1, 57'd1,    hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd2, 64'hFFFF_FFFF_FFFF_FFF8, 1'b1, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd3, 64'h7F,                  1'b0, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd2, 64'hF,                   1'b1, 57'd1,    hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd2, 64'h6,                   1'b1, '0,       hsd_pkg::STAT_DOUBLE,    6'd0},
        '{1'b1, 3'd2, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd0, 64'hF,                   1'b1, 57'd1,    hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd1, 64'h5,                   1'b0, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd7, ALL_CW,                  1'b1, ALL_DATA, hsd_pkg::STAT_NONE,      6'd0},
        '{1'b0, 3'd7, 64'h1,                   1'b1, '0,       hsd_pkg::STAT_CORRECTED, 6'd1},
        '{1'b1, 3'd4, 64'hA5A5,                1'b0, '0,       hsd_pkg::STAT_NONE,      6'd0},
        '{1'b1, 3'd5, 64'h1234_5678_9ABC_DEF0, 1'b0, '0,       hsd_pkg::STAT_NONE,      6'd0}
    };

    hamming_sec_secded_decoder DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_codeword       (i_codeword),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_data_out       (o_data_out),
        .o_status         (o_status),
        .o_error_position (o_error_position),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int eff_log2(input logic [2:0] klog);
        if (klog < hsd_pkg::K_MIN) return int'(hsd_pkg::K_MIN);
        if (klog > hsd_pkg::K_TOP) return int'(hsd_pkg::K_TOP);
        return int'(klog);
    endfunction

    function automatic hsd_pkg::t_result decode_predict(input logic [hsd_pkg::CW_W-1:0] cw,
                                                        input bit sd,
                                                        input logic [2:0] klog);
        int               top;
        int               p;
        int               syn;
        int               nd;
        bit               par;
        logic [63:0]      bits;
        hsd_pkg::t_result r;
        top  = (1 << eff_log2(klog)) - 1;
        bits = '0;
        syn  = 0;
        par  = 1'b0;
        r    = '0;
        for (p = 0; p <= top; p++) begin
            if (p == 0 && !sd) continue;
            if (sd) bits[p] = cw[p];
            else bits[p] = cw[p-1];
            if (bits[p]) begin
                syn = syn ^ p;
                par = ~par;
            end
        end
        if (syn != 0) begin
            if (sd && !par) begin
                r.status = hsd_pkg::STAT_DOUBLE;
                return r;
            end
            bits[syn] = ~bits[syn];
            r.status  = hsd_pkg::STAT_CORRECTED;
            r.epos    = syn[hsd_pkg::POS_W-1:0];
        end else if (sd && par) begin
            r.status = hsd_pkg::STAT_CORRECTED;
        end
        nd = 0;
        for (p = 1; p <= top; p++) begin
            if ((p & (p - 1)) == 0) continue;
            r.data[nd] = bits[p];
            nd++;
        end
        return r;
    endfunction

    // encode payload into a clean codeword, then flip bits and fill the unused top
    function automatic logic [hsd_pkg::CW_W-1:0] build_codeword(input logic [63:0] payload,
                                                                input bit sd,
                                                                input logic [2:0] klog,
                                                                input int nflip,
                                                                input logic [63:0] noise);
        int          k;
        int          top;
        int          len;
        int          p;
        int          nd;
        int          syn;
        int          i;
        int          lo;
        int          f0;
        int          f1;
        logic [63:0] pb;
        logic [63:0] cw;
        logic [63:0] used;
        k   = eff_log2(klog);
        top = (1 << k) - 1;
        pb  = '0;
        nd  = 0;
        syn = 0;
        for (p = 1; p <= top; p++) begin
            if ((p & (p - 1)) == 0) continue;
            pb[p] = payload[nd];
            if (pb[p]) syn = syn ^ p;
            nd++;
        end
        for (i = 0; i < k; i++) pb[1 << i] = syn[i];
        if (sd) pb[0] = ^pb;
        lo = sd ? 0 : 1;
        f0 = $urandom_range(lo, top);
        if (nflip >= 1) pb[f0] = ~pb[f0];
        if (nflip >= 2) begin
            do f1 = $urandom_range(lo, top); while (f1 == f0);
            pb[f1] = ~pb[f1];
        end
        if (nflip >= 3) begin
            f0 = $urandom_range(lo, top);
            pb[f0] = ~pb[f0];
        end
        cw   = sd ? pb : (pb >> 1);
        len  = sd ? top + 1 : top;
        used = (len == 64) ? '1 : ((64'd1 << len) - 64'd1);
        return (cw & used) | (noise & ~used);
    endfunction

    task automatic send_codeword(input logic [hsd_pkg::CW_W-1:0] cw,
                                 input hsd_pkg::t_result want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_codeword <= cw;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(want);
        words_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg_reg(input logic [hsd_pkg::IDX_W-1:0] idx,
                                 input logic [hsd_pkg::CFG_W-1:0] wdata);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= wdata;
        if (idx == hsd_pkg::CFG_SECDED_MODE) mode_shadow = wdata[0];
        else klog_shadow = wdata[2:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_config(input bit sd, input logic [2:0] klog);
        logic [1:0] junk;
        junk = 2'($urandom_range(0, 3));
        wait_idle();
        if (sd != mode_shadow) write_cfg_reg(hsd_pkg::CFG_SECDED_MODE, {junk, sd});
        if (klog != klog_shadow) write_cfg_reg(hsd_pkg::CFG_LENGTH_LOG2, klog);
    endtask

    // result side: check each beat, random back-pressure, one long hold-off
    initial begin
        hsd_pkg::t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat, got data %h status %0d pos %0d",
                             $time, o_data_out, o_status, o_error_position);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_data_out !== want.data) begin
                        $display("%0t: data_out mismatch, expected %h, got %h",
                                 $time, want.data, o_data_out);
                        mismatches++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_status);
                        mismatches++;
                    end
                    if (o_error_position !== want.epos) begin
                        $display("%0t: error_position mismatch, expected %0d, got %0d",
                                 $time, want.epos, o_error_position);
                        mismatches++;
                    end
                end
                beats_out++;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_ready <= 1'b0;
            end else if (!pressure_done && beats_out >= 300) begin
                pressure_done = 1'b1;
                hold_cnt      = 80;
                i_ready      <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int               n;
        int               seg;
        int               pick;
        int               nflip;
        bit               sd;
        logic [2:0]       klog;
        logic [63:0]      cw;
        logic [63:0]      noise;
        hsd_pkg::t_result want;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_DIR; n++) begin
            if (dir_vectors[n].sd != mode_shadow || dir_vectors[n].klog != klog_shadow)
                apply_config(dir_vectors[n].sd, dir_vectors[n].klog);
            if (dir_vectors[n].typed) begin
                want.data   = dir_vectors[n].want_data;
                want.status = dir_vectors[n].want_status;
                want.epos   = dir_vectors[n].want_pos;
            end else begin
                want = decode_predict(dir_vectors[n].cw, mode_shadow, klog_shadow);
            end
            send_codeword(dir_vectors[n].cw, want);
        end

        for (seg = 0; seg < N_SEG; seg++) begin
            sd   = 1'($urandom_range(0, 1));
            klog = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(2, 6))
                                                : 3'($urandom_range(0, 7));
            apply_config(sd, klog);
            for (n = 0; n < SEG_LEN; n++) begin
                if (words_sent >= 734) begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end else if (words_sent >= 367) begin
                    send_idle_pct = 52;
                    recv_idle_pct = 16;
                end
                pick  = $urandom_range(0, 99);
                noise = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
                if (pick < 15) begin
                    cw = {$urandom, $urandom};
                end else begin
                    nflip = (pick < 30) ? 0 : (pick < 65) ? 1 : (pick < 90) ? 2 : 3;
                    cw = build_codeword({$urandom, $urandom}, mode_shadow, klog_shadow,
                                        nflip, noise);
                end
                want = decode_predict(cw, mode_shadow, klog_shadow);
                send_codeword(cw, want);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
